// ===== hdl/dq_pkg.sv =====
`default_nettype none

package dq_pkg;

   // Word and result field widths
   localparam int WordWidth     = 32;
   localparam int ActionWidth   = 3;
   localparam int StatusWidth   = 2;
   localparam int CountOutWidth = 11;

   // Action codes on the request channel
   localparam logic [ActionWidth-1:0] ACT_NONE       = 3'd0;
   localparam logic [ActionWidth-1:0] ACT_PUSH_FRONT = 3'd1;
   localparam logic [ActionWidth-1:0] ACT_PUSH_BACK  = 3'd2;
   localparam logic [ActionWidth-1:0] ACT_POP_FRONT  = 3'd3;
   localparam logic [ActionWidth-1:0] ACT_POP_BACK   = 3'd4;

   // Status codes on the response channel
   localparam logic [StatusWidth-1:0] ST_OK    = 2'd0;
   localparam logic [StatusWidth-1:0] ST_EMPTY = 2'd1;
   localparam logic [StatusWidth-1:0] ST_FULL  = 2'd2;

   // Operation that actually took effect (failed actions become OP_NONE)
   typedef enum logic [2:0] {
      OP_NONE,
      OP_PUSH_FRONT,
      OP_PUSH_BACK,
      OP_POP_FRONT,
      OP_POP_BACK
   } dq_op_type;

   typedef struct packed {
      dq_op_type               op;
      logic [StatusWidth-1:0]  status;
   } dq_ctrl_type;

   typedef struct packed {
      logic signed [WordWidth-1:0] popped_value;
      logic [StatusWidth-1:0]      status;
      logic [CountOutWidth-1:0]    element_count;
      logic                        is_empty;
      logic signed [WordWidth-1:0] front_value;
      logic signed [WordWidth-1:0] back_value;
   } dq_result_type;

endpackage

`default_nettype wire

// ===== hdl/dq_ram.sv =====
`default_nettype none

module dq_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024,
   localparam int AddrWidth = $clog2(Depth)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [Width-1:0]     wr_data,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [Width-1:0]     rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write one word, read one word with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/dq_ptr.sv =====
`default_nettype none

module dq_ptr #(
   parameter int Capacity = 1024,
   localparam int PtrWidth = $clog2(Capacity),
   localparam int CntWidth = $clog2(Capacity + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [dq_pkg::ActionWidth-1:0] action,
   input  logic signed [dq_pkg::WordWidth-1:0] push_value,
   output logic                          wr_en,
   output logic [PtrWidth-1:0]           wr_addr,
   output logic [PtrWidth-1:0]           rd_addr,
   output logic                          stage_valid,
   output dq_pkg::dq_ctrl_type           stage_ctrl,
   output logic signed [dq_pkg::WordWidth-1:0] stage_value,
   output logic [CntWidth-1:0]           stage_count
);

   import dq_pkg::*;

   localparam logic [PtrWidth-1:0] LastSlot  = PtrWidth'(Capacity - 1);
   localparam logic [CntWidth-1:0] FullCount = CntWidth'(Capacity);

   logic [PtrWidth-1:0] head_ff, head_in;
   logic [PtrWidth-1:0] tail_ff, tail_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic [PtrWidth-1:0] head_next, head_prev, tail_next, tail_prev, tail_prev2;
   dq_ctrl_type         ctrl_in;
   logic                write_req;

   logic                stage_valid_ff;
   dq_ctrl_type         stage_ctrl_ff;
   logic signed [WordWidth-1:0] stage_value_ff;
   logic [CntWidth-1:0] stage_count_ff;

   // Neighbor slots with wrap at the buffer ends
   always_comb begin
      head_next  = (head_ff == LastSlot) ? '0 : head_ff + PtrWidth'(1);
      head_prev  = (head_ff == '0) ? LastSlot : head_ff - PtrWidth'(1);
      tail_next  = (tail_ff == LastSlot) ? '0 : tail_ff + PtrWidth'(1);
      tail_prev  = (tail_ff == '0) ? LastSlot : tail_ff - PtrWidth'(1);
      tail_prev2 = (tail_prev == '0) ? LastSlot : tail_prev - PtrWidth'(1);
   end

   // Decode the action, move pointers, address the store
   always_comb begin
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      ctrl_in.op     = OP_NONE;
      ctrl_in.status = ST_OK;
      write_req      = 1'b0;
      wr_addr        = tail_ff;
      rd_addr        = head_next;
      case (action)
         ACT_PUSH_FRONT: begin
            if (count_ff == FullCount) begin
               ctrl_in.status = ST_FULL;
            end else begin
               ctrl_in.op = OP_PUSH_FRONT;
               head_in    = head_prev;
               write_req  = 1'b1;
               wr_addr    = head_prev;
               count_in   = count_ff + CntWidth'(1);
            end
         end
         ACT_PUSH_BACK: begin
            if (count_ff == FullCount) begin
               ctrl_in.status = ST_FULL;
            end else begin
               ctrl_in.op = OP_PUSH_BACK;
               tail_in    = tail_next;
               write_req  = 1'b1;
               wr_addr    = tail_ff;
               count_in   = count_ff + CntWidth'(1);
            end
         end
         ACT_POP_FRONT: begin
            if (count_ff == '0) begin
               ctrl_in.status = ST_EMPTY;
            end else begin
               ctrl_in.op = OP_POP_FRONT;
               head_in    = head_next;
               rd_addr    = head_next;
               count_in   = count_ff - CntWidth'(1);
            end
         end
         ACT_POP_BACK: begin
            if (count_ff == '0) begin
               ctrl_in.status = ST_EMPTY;
            end else begin
               ctrl_in.op = OP_POP_BACK;
               tail_in    = tail_prev;
               rd_addr    = tail_prev2;
               count_in   = count_ff - CntWidth'(1);
            end
         end
         ACT_NONE: begin
            ctrl_in.op = OP_NONE;
         end
         default: begin
            ctrl_in.op = OP_NONE;
         end
      endcase
   end

   assign wr_en = write_req && accept;

   // Advance pointers and count on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= accept;
         if (accept) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
      end
   end

   // Hold the decoded request for the end-word stage
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ctrl_ff  <= ctrl_in;
         stage_value_ff <= push_value;
         stage_count_ff <= count_in;
      end
   end

   assign stage_valid = stage_valid_ff;
   assign stage_ctrl  = stage_ctrl_ff;
   assign stage_value = stage_value_ff;
   assign stage_count = stage_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCount)
      else $error("stored count above capacity");

   a_ptr_meet: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FullCount) |-> head_ff == tail_ff)
      else $error("pointers apart on empty or full buffer");

endmodule

`default_nettype wire

// ===== hdl/dq_ends.sv =====
`default_nettype none

module dq_ends #(
   parameter int Capacity = 1024,
   localparam int CntWidth = $clog2(Capacity + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          stage_valid,
   input  dq_pkg::dq_ctrl_type           stage_ctrl,
   input  logic signed [dq_pkg::WordWidth-1:0] stage_value,
   input  logic [CntWidth-1:0]           stage_count,
   input  logic [dq_pkg::WordWidth-1:0]  rd_data,
   output logic                          res_valid,
   output dq_pkg::dq_result_type         res_data
);

   import dq_pkg::*;

   logic signed [WordWidth-1:0] front_ff, front_in;
   logic signed [WordWidth-1:0] back_ff, back_in;
   logic signed [WordWidth-1:0] popped;
   logic                        left_none, left_one;

   assign left_none = (stage_count == '0);
   assign left_one  = (stage_count == CntWidth'(1));

   // Work out the new end words from the cached ends and the prefetched word
   always_comb begin
      front_in = front_ff;
      back_in  = back_ff;
      popped   = '0;
      case (stage_ctrl.op)
         OP_PUSH_FRONT: begin
            front_in = stage_value;
            if (left_one) begin
               back_in = stage_value;
            end
         end
         OP_PUSH_BACK: begin
            back_in = stage_value;
            if (left_one) begin
               front_in = stage_value;
            end
         end
         OP_POP_FRONT: begin
            popped = front_ff;
            if (left_none) begin
               front_in = '0;
               back_in  = '0;
            end else if (left_one) begin
               front_in = back_ff;
            end else begin
               front_in = $signed(rd_data);
            end
         end
         OP_POP_BACK: begin
            popped = back_ff;
            if (left_none) begin
               front_in = '0;
               back_in  = '0;
            end else if (left_one) begin
               back_in = front_ff;
            end else begin
               back_in = $signed(rd_data);
            end
         end
         default: begin
            popped = '0;
         end
      endcase
   end

   // Keep the end words cached
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
      end else if (stage_valid) begin
         front_ff <= front_in;
         back_ff  <= back_in;
      end
   end

   // Assemble the response
   always_comb begin
      res_data.popped_value  = popped;
      res_data.status        = stage_ctrl.status;
      res_data.element_count = CountOutWidth'(stage_count);
      res_data.is_empty      = left_none;
      res_data.front_value   = front_in;
      res_data.back_value    = back_in;
   end

   assign res_valid = stage_valid;

   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      (stage_valid && left_none) |=> (front_ff == '0 && back_ff == '0))
      else $error("end words not cleared on empty buffer");

endmodule

`default_nettype wire

// ===== hdl/dq_rsp_fifo.sv =====
`default_nettype none

module dq_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  dq_pkg::dq_result_type in_data,
   input  logic                  pending,
   output logic                  room,
   output logic                  out_valid,
   input  logic                  out_ready,
   output dq_pkg::dq_result_type out_data
);

   import dq_pkg::*;

   // One slot per response that can be in flight behind a stalled consumer
   localparam int Slots = 3;

   dq_result_type slot_ff [Slots];
   logic [1:0]    wr_idx_ff, rd_idx_ff, count_ff;
   logic          wr_en, rd_en;

   assign wr_en = in_valid;
   assign rd_en = out_valid && out_ready;

   // Advance indexes and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_idx_ff <= (wr_idx_ff == 2'(Slots - 1)) ? '0 : wr_idx_ff + 2'd1;
         end
         if (rd_en) begin
            rd_idx_ff <= (rd_idx_ff == 2'(Slots - 1)) ? '0 : rd_idx_ff + 2'd1;
         end
         count_ff <= count_ff + 2'(wr_en) - 2'(rd_en);
      end
   end

   // Store the response
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_idx_ff] <= in_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_idx_ff];
   assign room      = (3'(count_ff) + 3'(pending)) < 3'(Slots);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> count_ff != 2'(Slots))
      else $error("response written into full buffer");

endmodule

`default_nettype wire

// ===== hdl/double_ended_queue_top.sv =====
// An accepted request is registered in the pointer stage, and its response in the response
// buffer. Throughput: one request per cycle while the buffer has room; the store has one
// write and one read port and each action writes or prefetches at most one word, while the
// end words sit in registers. A three-slot response buffer lets requests keep flowing
// while a response waits. Reset clears pointers, count, cached end words and the response
// buffer; the word store itself is not cleared, and requests are taken right after reset.
`default_nettype none

module double_ended_queue_top #(
   parameter int CAPACITY = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [dq_pkg::ActionWidth-1:0]       req_action,
   input  logic signed [dq_pkg::WordWidth-1:0]  req_push_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [dq_pkg::WordWidth-1:0]  rsp_popped_value,
   output logic [dq_pkg::StatusWidth-1:0]       rsp_status,
   output logic [dq_pkg::CountOutWidth-1:0]     rsp_element_count,
   output logic                                 rsp_is_empty,
   output logic signed [dq_pkg::WordWidth-1:0]  rsp_front_value,
   output logic signed [dq_pkg::WordWidth-1:0]  rsp_back_value
);

   import dq_pkg::*;

   localparam int PtrWidth = $clog2(CAPACITY);
   localparam int CntWidth = $clog2(CAPACITY + 1);

   logic                        accept;
   logic                        wr_en;
   logic [PtrWidth-1:0]         wr_addr, rd_addr;
   logic [WordWidth-1:0]        rd_data;
   logic                        stage_valid;
   dq_ctrl_type                 stage_ctrl;
   logic signed [WordWidth-1:0] stage_value;
   logic [CntWidth-1:0]         stage_count;
   logic                        res_valid;
   dq_result_type               res_data;
   dq_result_type               rsp_data;
   logic                        room;

   // Hold off requests during reset and while the response buffer has no room
   assign req_ready = room && !reset;
   assign accept    = req_valid && req_ready;

   // Pointer and count update, store addressing
   dq_ptr #(
      .Capacity (CAPACITY)
   ) u_ptr (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .action      (req_action),
      .push_value  (req_push_value),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .rd_addr     (rd_addr),
      .stage_valid (stage_valid),
      .stage_ctrl  (stage_ctrl),
      .stage_value (stage_value),
      .stage_count (stage_count)
   );

   // Word store
   dq_ram #(
      .Width (WordWidth),
      .Depth (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_push_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // End words and response assembly
   dq_ends #(
      .Capacity (CAPACITY)
   ) u_ends (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_ctrl  (stage_ctrl),
      .stage_value (stage_value),
      .stage_count (stage_count),
      .rd_data     (rd_data),
      .res_valid   (res_valid),
      .res_data    (res_data)
   );

   // Response buffer
   dq_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res_data),
      .pending   (stage_valid),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_popped_value  = rsp_data.popped_value;
   assign rsp_status        = rsp_data.status;
   assign rsp_element_count = rsp_data.element_count;
   assign rsp_is_empty      = rsp_data.is_empty;
   assign rsp_front_value   = rsp_data.front_value;
   assign rsp_back_value    = rsp_data.back_value;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`default_nettype none

module testbench;
   import dq_pkg::*;

   localparam int Depth         = 1024;
   localparam int MaxGap        = 11;
   localparam int NoisePct      = 4;
   localparam int HoldOffCycles = 200;
   localparam int WatchdogLimit = 4000;
   localparam int SettleCycles  = 20;

   localparam logic [ActionWidth-1:0] ActUnusedLow  = ACT_POP_BACK + ActionWidth'(1);
   localparam logic [ActionWidth-1:0] ActUnusedHigh = '1;

   localparam logic signed [WordWidth-1:0] WordMax = 32'sh7fff_ffff;
   localparam logic signed [WordWidth-1:0] WordMin = 32'sh8000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid      = 1'b0;
   logic                          req_ready;
   logic [ActionWidth-1:0]        req_action     = ACT_NONE;
   logic signed [WordWidth-1:0]   req_push_value = '0;
   logic                          rsp_valid;
   logic                          rsp_ready      = 1'b0;
   logic signed [WordWidth-1:0]   rsp_popped_value;
   logic [StatusWidth-1:0]        rsp_status;
   logic [CountOutWidth-1:0]      rsp_element_count;
   logic                          rsp_is_empty;
   logic signed [WordWidth-1:0]   rsp_front_value;
   logic signed [WordWidth-1:0]   rsp_back_value;

   // Mirror of the deque contents
   logic signed [WordWidth-1:0] held_words [Depth];
   int head_slot  = 0;
   int tail_slot  = 0;
   int held_count = 0;

   dq_result_type deque_results[$];

   bit req_idle_on     = 1'b0;
   bit rsp_idle_on     = 1'b0;
   int rsp_hold_cycles = 0;
   int stalled_cycles  = 0;
   int mismatches      = 0;

   // Run statistics
   int requests_sent  = 0;
   int responses_seen = 0;
   int pushes         = 0;
   int pops           = 0;
   int full_drops     = 0;
   int empty_pops     = 0;
   int peak_count     = 0;

   double_ended_queue_top #(
      .CAPACITY(Depth)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_push_value    (req_push_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_popped_value  (rsp_popped_value),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_front_value   (rsp_front_value),
      .rsp_back_value    (rsp_back_value)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Apply one action to the mirror and return the response it should give
   function automatic dq_result_type deque_apply_action(
      input logic [ActionWidth-1:0]      action,
      input logic signed [WordWidth-1:0] value
   );
      dq_result_type res;
      res        = '0;
      res.status = ST_OK;
      case (action)
         ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if (held_count >= Depth) begin
               res.status = ST_FULL;
               full_drops++;
            end else if (action == ACT_PUSH_FRONT) begin
               head_slot = (head_slot + Depth - 1) % Depth;
               held_words[head_slot] = value;
               held_count++;
               pushes++;
            end else begin
               held_words[tail_slot] = value;
               tail_slot = (tail_slot + 1) % Depth;
               held_count++;
               pushes++;
            end
         end
         ACT_POP_FRONT, ACT_POP_BACK: begin
            if (held_count == 0) begin
               res.status = ST_EMPTY;
               empty_pops++;
            end else if (action == ACT_POP_FRONT) begin
               res.popped_value = held_words[head_slot];
               head_slot = (head_slot + 1) % Depth;
               held_count--;
               pops++;
            end else begin
               tail_slot = (tail_slot + Depth - 1) % Depth;
               res.popped_value = held_words[tail_slot];
               held_count--;
               pops++;
            end
         end
         default: ;
      endcase
      res.element_count = CountOutWidth'(held_count);
      res.is_empty      = (held_count == 0);
      if (held_count != 0) begin
         res.front_value = held_words[head_slot];
         res.back_value  = held_words[(tail_slot + Depth - 1) % Depth];
      end
      if (held_count > peak_count) peak_count = held_count;
      return res;
   endfunction

   // Offer one request, hold it until accepted, then record its response
   task automatic send_request(
      input logic [ActionWidth-1:0]      action,
      input logic signed [WordWidth-1:0] value
   );
      int gap;
      gap = req_idle_on ? $urandom_range(0, MaxGap) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= action;
      req_push_value <= value;
      do @(posedge clock); while (!req_ready);
      deque_results.insert(deque_results.size(), deque_apply_action(action, value));
      requests_sent++;
   endtask

   // Pick an action: a little noise, then pushes with the given weight, pops otherwise
   function automatic logic [ActionWidth-1:0] draw_action(input int push_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < NoisePct)
         return ($urandom_range(0, 1) != 0) ? ACT_NONE :
                ActionWidth'($urandom_range(ActUnusedLow, ActUnusedHigh));
      if (roll < NoisePct + push_pct)
         return ($urandom_range(0, 1) != 0) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
      return ($urandom_range(0, 1) != 0) ? ACT_POP_FRONT : ACT_POP_BACK;
   endfunction

   // Random word with the extremes mixed in
   function automatic logic signed [WordWidth-1:0] draw_word();
      case ($urandom_range(0, 7))
         0:       return WordMax;
         1:       return WordMin;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Edge cases on an empty and a short queue
   task automatic test_directed();
      int code;
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      send_request(ACT_POP_FRONT, '0);
      send_request(ACT_POP_BACK, WordMax);
      send_request(ACT_NONE, WordMin);
      send_request(ACT_PUSH_BACK, WordMax);
      send_request(ACT_PUSH_FRONT, WordMin);
      send_request(ACT_NONE, '0);
      send_request(ACT_PUSH_BACK, '1);
      send_request(ACT_PUSH_FRONT, '0);
      // unused codes must leave the queue alone
      for (code = ActUnusedLow; code <= ActUnusedHigh; code++)
         send_request(ActionWidth'(code), draw_word());
      send_request(ACT_POP_BACK, '0);
      send_request(ACT_POP_FRONT, '1);
      send_request(ACT_POP_FRONT, '0);
      send_request(ACT_POP_BACK, '0);
      send_request(ACT_POP_BACK, '0);
      send_request(ACT_POP_FRONT, '0);
      send_request(ACT_PUSH_FRONT, 32'shaaaa_aaaa);
      send_request(ACT_PUSH_BACK, 32'sh5555_5555);
      send_request(ACT_POP_FRONT, '0);
      send_request(ACT_POP_FRONT, '0);
      send_request(ACT_POP_BACK, '0);
   endtask

   // Balanced traffic near empty, so pops on empty and pointer wrap show up
   task automatic test_mixed_random(input int count);
      int i;
      for (i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            req_idle_on = 1'($urandom_range(0, 1));
            rsp_idle_on = 1'($urandom_range(0, 1));
         end
         send_request(draw_action(48), draw_word());
      end
   endtask

   // Push-heavy traffic until the store is full
   task automatic test_fill_to_full();
      int i;
      i = 0;
      while (held_count < Depth) begin
         if (i % 128 == 0) begin
            req_idle_on = 1'($urandom_range(0, 1));
            rsp_idle_on = 1'($urandom_range(0, 1));
         end
         send_request(draw_action(92), draw_word());
         i++;
      end
   endtask

   // Hover at capacity so pushes get dropped
   task automatic test_near_full(input int count);
      int i;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      for (i = 0; i < count; i++)
         send_request(draw_action(60), draw_word());
   endtask

   // Hold the response side off while requests keep coming
   task automatic test_backpressure(input int count);
      int i;
      req_idle_on     = 1'b0;
      rsp_idle_on     = 1'b0;
      rsp_hold_cycles = HoldOffCycles;
      for (i = 0; i < count; i++)
         send_request(draw_action(50), draw_word());
   endtask

   // Compare one response field
   task automatic check_field(
      input string            field,
      input logic [WordWidth-1:0] want,
      input logic [WordWidth-1:0] got
   );
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatches++;
      end
   endtask

   // Drain responses with random stalls and an occasional long hold-off
   initial begin : rsp_drain
      int stall;
      @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = rsp_idle_on ? $urandom_range(0, MaxGap) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Check each accepted response against the oldest prediction
   always @(posedge clock) begin : rsp_check
      dq_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (deque_results.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
         end else begin
            want = deque_results[0];
            deque_results.delete(0);
            check_field("popped_value", want.popped_value, rsp_popped_value);
            check_field("status", WordWidth'(want.status), WordWidth'(rsp_status));
            check_field("element_count", WordWidth'(want.element_count),
                        WordWidth'(rsp_element_count));
            check_field("is_empty", WordWidth'(want.is_empty), WordWidth'(rsp_is_empty));
            check_field("front_value", want.front_value, rsp_front_value);
            check_field("back_value", want.back_value, rsp_back_value);
         end
      end
   end

   // Abort when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
         if (stalled_cycles >= WatchdogLimit) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_mixed_random(120);
      test_fill_to_full();
      test_near_full(60);
      test_backpressure(40);
      test_mixed_random(60);

      req_valid <= 1'b0;
      while (deque_results.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);

      $display("Covered %0d requests: %0d pushes, %0d dropped on full, %0d pops, %0d on empty",
               requests_sent, pushes, full_drops, pops, empty_pops);
      $display("Peak depth %0d of %0d, %0d responses checked, %0d mismatches",
               peak_count, Depth, responses_seen, mismatches);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/dq_pkg.sv
hdl/dq_ram.sv
hdl/dq_ptr.sv
hdl/dq_ends.sv
hdl/dq_rsp_fifo.sv
hdl/double_ended_queue_top.sv
sim/testbench.sv
